// ===== sv/ths_pkg.sv =====
// Shared types and constants for the terrain height sampler.
// No dependencies; every other file of the block but ths_ram imports this package.
package ths_pkg;

  localparam int POS_W     = 16;
  localparam int SAMPLE_W  = 8;
  localparam int HEIGHT_W  = 16;
  localparam int DIM_REG_W = 9;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;
  localparam int NUM_BANKS = 4;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 9'd256;

  // Kind of an input beat, carried on s_tuser.
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_GRID_WIDTH = 1'b0,
    REG_GRID_DEPTH = 1'b1
  } reg_index_t;

  // Per-item control that travels down the pipeline beside the payload.
  typedef struct packed {
    logic valid;     // stage holds an item
    logic query;     // item is a query (else a write)
    logic in_store;  // write position lies inside the sample store
    logic oor;       // query cell exceeds the configured grid
    logic lower;     // query falls in the lower triangle of its cell
    logic col_odd;   // low bit of the cell column
    logic row_odd;   // low bit of the cell row
  } ths_ctl_t;

endpackage

// ===== sv/ths_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ths_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ths_decode.sv =====
// First pipeline stage: splits a position into cell and fractions, checks the grid
// and store bounds and forms the three triangle weights. Depends on ths_pkg.
module ths_decode
  import ths_pkg::*;
#(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic                          action,
  input  logic [POS_W-1:0]              x_pos,
  input  logic [POS_W-1:0]              z_pos,
  input  logic [SAMPLE_W-1:0]           sample,
  input  logic [DIM_REG_W-1:0]          grid_width,
  input  logic [DIM_REG_W-1:0]          grid_depth,
  output ths_ctl_t                      ctl,
  output logic [$clog2(MAX_DIM)-1:0]    col,
  output logic [$clog2(MAX_DIM)-1:0]    row,
  output logic [SAMPLE_W-1:0]           sample_q,
  output logic [FRAC_BITS:0]            w_a,
  output logic [FRAC_BITS:0]            w_01,
  output logic [FRAC_BITS:0]            w_10
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int WW = FRAC_BITS + 1;
  localparam logic [16:0]   MAX_DIM_V = 17'(MAX_DIM);
  localparam logic [WW-1:0] ONE       = {1'b1, {FRAC_BITS{1'b0}}};

  logic [16:0]   col_full;
  logic [16:0]   row_full;
  logic [16:0]   lim_w;
  logic [16:0]   lim_d;
  logic [WW-1:0] fx;
  logic [WW-1:0] fz;
  logic [WW-1:0] fsum;
  ths_ctl_t      ctl_next;
  logic [WW-1:0] w_a_next;
  logic [WW-1:0] w_01_next;
  logic [WW-1:0] w_10_next;

  always_comb begin
    col_full = 17'(x_pos >> FRAC_BITS);
    row_full = 17'(z_pos >> FRAC_BITS);
    lim_w    = (17'(grid_width) > MAX_DIM_V) ? MAX_DIM_V : 17'(grid_width);
    lim_d    = (17'(grid_depth) > MAX_DIM_V) ? MAX_DIM_V : 17'(grid_depth);
    fx       = {1'b0, x_pos[FRAC_BITS-1:0]};
    fz       = {1'b0, z_pos[FRAC_BITS-1:0]};
    fsum     = fx + fz;

    ctl_next.valid    = in_valid;
    ctl_next.query    = (action == ACT_QUERY);
    ctl_next.in_store = (col_full < MAX_DIM_V) && (row_full < MAX_DIM_V);
    ctl_next.oor      = (col_full + 17'd1 >= lim_w) || (row_full + 17'd1 >= lim_d);
    ctl_next.lower    = (fsum < ONE);
    ctl_next.col_odd  = col_full[0];
    ctl_next.row_odd  = row_full[0];

    // Barycentric weights; each lies in 0..ONE and the three sum to ONE.
    if (ctl_next.lower) begin
      w_a_next  = ONE - fsum;
      w_01_next = fz;
      w_10_next = fx;
    end else begin
      w_a_next  = fsum - ONE;
      w_01_next = ONE - fx;
      w_10_next = ONE - fz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (advance) begin
      ctl <= ctl_next;
    end
    if (advance) begin
      col      <= CW'(col_full);
      row      <= CW'(row_full);
      sample_q <= sample;
      w_a      <= w_a_next;
      w_01     <= w_01_next;
      w_10     <= w_10_next;
    end
  end

endmodule

// ===== sv/ths_store.sv =====
// Sample store split into four banks by the parity of column and row, so that the
// four corners of any cell sit in distinct banks. Depends on ths_pkg and ths_ram.
module ths_store
  import ths_pkg::*;
#(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  ths_ctl_t                            ctl_in,
  input  logic [$clog2(MAX_DIM)-1:0]          col,
  input  logic [$clog2(MAX_DIM)-1:0]          row,
  input  logic [SAMPLE_W-1:0]                 sample,
  input  logic [FRAC_BITS:0]                  w_a_in,
  input  logic [FRAC_BITS:0]                  w_01_in,
  input  logic [FRAC_BITS:0]                  w_10_in,
  output ths_ctl_t                            ctl_out,
  output logic [FRAC_BITS:0]                  w_a,
  output logic [FRAC_BITS:0]                  w_01,
  output logic [FRAC_BITS:0]                  w_10,
  output logic [NUM_BANKS-1:0][SAMPLE_W-1:0]  bank_data
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int HW    = (CW > 1) ? CW - 1 : 1;
  localparam int AW    = 2 * HW;
  localparam int DEPTH = 1 << AW;

  logic [AW-1:0] waddr;
  ths_ctl_t      ctl_next;

  assign waddr = {HW'(row >> 1), HW'(col >> 1)};

  // Writes end here; only queries continue down the pipeline.
  always_comb begin
    ctl_next       = ctl_in;
    ctl_next.valid = ctl_in.valid && ctl_in.query;
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    // Bank b holds the samples whose column parity is b[0] and row parity b[1].
    localparam logic BX = 1'(b & 1);
    localparam logic BZ = 1'((b >> 1) & 1);

    logic [CW-1:0] bcol;
    logic [CW-1:0] brow;
    logic [AW-1:0] raddr;
    logic          we;

    always_comb begin
      bcol  = col + CW'(BX ^ col[0]);
      brow  = row + CW'(BZ ^ row[0]);
      raddr = {HW'(brow >> 1), HW'(bcol >> 1)};
      we    = advance && ctl_in.valid && !ctl_in.query && ctl_in.in_store &&
              (col[0] == BX) && (row[0] == BZ);
    end

    ths_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (sample),
      .re    (advance),
      .raddr (raddr),
      .rdata (bank_data[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (advance) begin
      ctl_out <= ctl_next;
    end
    if (advance) begin
      w_a  <= w_a_in;
      w_01 <= w_01_in;
      w_10 <= w_10_in;
    end
  end

endmodule

// ===== sv/ths_blend.sv =====
// Interpolation stages: routes the bank outputs to the triangle corners, forms the
// three weighted products, then sums them into the output register. Depends on ths_pkg.
module ths_blend
  import ths_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  ths_ctl_t                           ctl,
  input  logic [FRAC_BITS:0]                 w_a,
  input  logic [FRAC_BITS:0]                 w_01,
  input  logic [FRAC_BITS:0]                 w_10,
  input  logic [NUM_BANKS-1:0][SAMPLE_W-1:0] bank_data,
  output logic                               out_valid,
  output logic [HEIGHT_W-1:0]                height,
  output logic                               out_of_range
);

  localparam int PW = FRAC_BITS + 1 + SAMPLE_W;
  localparam int SW = PW + 2;

  logic [1:0]          idx_a;
  logic [1:0]          idx_01;
  logic [1:0]          idx_10;
  logic [SAMPLE_W-1:0] h_a;
  logic [SAMPLE_W-1:0] h_01;
  logic [SAMPLE_W-1:0] h_10;
  logic                p_valid;
  logic                p_oor;
  logic [PW-1:0]       p_a;
  logic [PW-1:0]       p_01;
  logic [PW-1:0]       p_10;
  logic [SW-1:0]       sum;

  always_comb begin
    // Bank index is {row parity, column parity}.
    idx_a  = ctl.lower ? {ctl.row_odd, ctl.col_odd} : {~ctl.row_odd, ~ctl.col_odd};
    idx_01 = {~ctl.row_odd, ctl.col_odd};
    idx_10 = {ctl.row_odd, ~ctl.col_odd};
    h_a    = bank_data[idx_a];
    h_01   = bank_data[idx_01];
    h_10   = bank_data[idx_10];
    sum    = SW'(p_a) + SW'(p_01) + SW'(p_10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      p_valid   <= ctl.valid;
      out_valid <= p_valid;
    end
    if (advance) begin
      p_oor        <= ctl.oor;
      p_a          <= PW'(h_a) * PW'(w_a);
      p_01         <= PW'(h_01) * PW'(w_01);
      p_10         <= PW'(h_10) * PW'(w_10);
      out_of_range <= p_oor;
      height       <= p_oor ? '0 : HEIGHT_W'(sum);
    end
  end

endmodule

// ===== sv/terrain_height_sampler.sv =====
// Terrain height sampler: top level with the stream ports and configuration registers.
// Depends on ths_pkg, ths_decode, ths_store, ths_blend and ths_ram.
//
// The block keeps a grid of 8-bit height samples and answers height queries at
// fixed-point positions. A write beat (tuser 0) stores its sample at the integer
// column and row of x_pos and z_pos; writes outside the store are dropped, and no
// write produces an output beat. A query beat (tuser 1) picks the lower triangle of its
// cell when the two fractions sum below one and the upper triangle otherwise, and
// returns the planar interpolation of the three corner heights with FRAC_BITS
// fraction bits. A query whose far corner lies outside grid_width by grid_depth
// returns height zero with out_of_range set. The block takes one beat every cycle
// unless stalled; a query's result passes the decode, store, product and output
// registers, and the pipeline stalls as a whole while a result waits at the output.
// The rate is set by the store, split into four banks by column and row parity, each
// with one read and one write port, so all corners of a cell are read at once. Writes
// and reads hit the store in the same stage, so a query always sees every earlier
// write. Samples never written read back undefined; there is no clearing pass. The
// user must change grid_width and grid_depth only while the block is idle; not enforced.
module terrain_height_sampler
  import ths_pkg::*;
#(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // x_pos [15:0], z_pos [31:16], sample [39:32]
  input  logic                  s_tuser,   // action [0]: 0 write, 1 query
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // height [15:0]
  output logic                  m_tuser,   // out_of_range [0]
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [DIM_REG_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int WW = FRAC_BITS + 1;

  logic [DIM_REG_W-1:0] grid_width;
  logic [DIM_REG_W-1:0] grid_depth;
  logic                 advance;

  ths_ctl_t      s1_ctl;
  logic [CW-1:0] s1_col;
  logic [CW-1:0] s1_row;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [WW-1:0] s1_w_a;
  logic [WW-1:0] s1_w_01;
  logic [WW-1:0] s1_w_10;

  ths_ctl_t      s2_ctl;
  logic [WW-1:0] s2_w_a;
  logic [WW-1:0] s2_w_01;
  logic [WW-1:0] s2_w_10;
  logic [NUM_BANKS-1:0][SAMPLE_W-1:0] s2_bank_data;

  // The whole pipeline moves together whenever the output register is free.
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= DIM_RESET;
      grid_depth <= DIM_RESET;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_GRID_WIDTH: grid_width <= cfg_data;
        REG_GRID_DEPTH: grid_depth <= cfg_data;
      endcase
    end
  end

  ths_decode #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (s_tvalid),
    .action     (s_tuser),
    .x_pos      (s_tdata[15:0]),
    .z_pos      (s_tdata[31:16]),
    .sample     (s_tdata[39:32]),
    .grid_width (grid_width),
    .grid_depth (grid_depth),
    .ctl        (s1_ctl),
    .col        (s1_col),
    .row        (s1_row),
    .sample_q   (s1_sample),
    .w_a        (s1_w_a),
    .w_01       (s1_w_01),
    .w_10       (s1_w_10)
  );

  ths_store #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .ctl_in    (s1_ctl),
    .col       (s1_col),
    .row       (s1_row),
    .sample    (s1_sample),
    .w_a_in    (s1_w_a),
    .w_01_in   (s1_w_01),
    .w_10_in   (s1_w_10),
    .ctl_out   (s2_ctl),
    .w_a       (s2_w_a),
    .w_01      (s2_w_01),
    .w_10      (s2_w_10),
    .bank_data (s2_bank_data)
  );

  ths_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .ctl          (s2_ctl),
    .w_a          (s2_w_a),
    .w_01         (s2_w_01),
    .w_10         (s2_w_10),
    .bank_data    (s2_bank_data),
    .out_valid    (m_tvalid),
    .height       (m_tdata),
    .out_of_range (m_tuser)
  );

endmodule

// ===== sv/ths_checker.sv =====
// Port-level checks for the terrain height sampler, bound to its top level.
// Depends on ths_pkg and terrain_height_sampler.
module ths_checker
  import ths_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser
);

  // No result may be offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // A query outside the grid reports height zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("out-of-range result with nonzero height");

  // The input side is open exactly when the output register can move.
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output state");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind terrain_height_sampler ths_checker u_ths_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== dv/terrain_height_sampler_check.sv =====
`timescale 1ns / 1ps
// Scoreboard for the terrain height sampler: watches the input, result and configuration
// channels, keeps a shadow sample grid and compares every result beat with its prediction.
// Depends on ths_pkg for widths, the action kinds and the register indexes.
module terrain_height_sampler_check
  import ths_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tuser,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [DIM_REG_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam int DIM  = 256;
  localparam int FRAC = 8;
  localparam int ONE  = 1 << FRAC;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                out_of_range;
  } height_result_t;

  height_result_t       pending_heights[$];
  logic [SAMPLE_W-1:0]  shadow_grid [DIM*DIM];
  logic [DIM_REG_W-1:0] width_reg;
  logic [DIM_REG_W-1:0] depth_reg;

  // Planar interpolation over the triangle of the cell that holds the position.
  function automatic height_result_t interp_height(logic [POS_W-1:0] xp, logic [POS_W-1:0] zp);
    int col, row, fx, fz, w, d, h00, h10, h01, h11, acc;
    height_result_t r;
    col = int'(xp) >> FRAC;
    row = int'(zp) >> FRAC;
    fx  = int'(xp) & (ONE - 1);
    fz  = int'(zp) & (ONE - 1);
    w   = (width_reg > DIM) ? DIM : int'(width_reg);
    d   = (depth_reg > DIM) ? DIM : int'(depth_reg);
    r.out_of_range = 1'b0;
    if (col + 1 >= w || row + 1 >= d) begin
      r.height       = '0;
      r.out_of_range = 1'b1;
      return r;
    end
    h10 = int'(shadow_grid[row*DIM + col + 1]);
    h01 = int'(shadow_grid[(row+1)*DIM + col]);
    if (fx + fz < ONE) begin
      h00 = int'(shadow_grid[row*DIM + col]);
      acc = h00*ONE + fx*(h10 - h00) + fz*(h01 - h00);
    end else begin
      h11 = int'(shadow_grid[(row+1)*DIM + col + 1]);
      acc = h11*ONE + (ONE - fx)*(h01 - h11) + (ONE - fz)*(h10 - h11);
    end
    r.height = acc[HEIGHT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    height_result_t want;
    if (rst) begin
      width_reg = DIM_RESET;
      depth_reg = DIM_RESET;
      pending_heights.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_WIDTH) width_reg = cfg_data;
        else depth_reg = cfg_data;
      end
      // Input beats are handled first so that a result offered as its query is taken would still match.
      if (s_tvalid && s_tready) begin
        if (s_tuser == ACT_WRITE) begin
          // With 8 integer bits a write position can never leave a 256 by 256 store.
          shadow_grid[{s_tdata[31:24], s_tdata[15:8]}] = s_tdata[39:32];
        end else begin
          pending_heights.push_back(interp_height(s_tdata[15:0], s_tdata[31:16]));
        end
      end
      if (m_tvalid && m_tready) begin
        if (pending_heights.size() == 0) begin
          $error("unexpected result beat: height %0d out_of_range %0b", m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = pending_heights.pop_front();
          if (m_tdata !== want.height) begin
            $error("height mismatch: expected %0d, actual %0d", want.height, m_tdata);
            fail_count++;
          end
          if (m_tuser !== want.out_of_range) begin
            $error("out_of_range mismatch: expected %0b, actual %0b",
                   want.out_of_range, m_tuser);
            fail_count++;
          end
        end
      end
      outstanding <= pending_heights.size();
    end
  end

endmodule

// ===== dv/terrain_height_sampler_test.sv =====
`timescale 1ns / 1ps
// Top of the terrain height sampler testbench: clock, reset, stimulus and the verdict.
// Depends on ths_pkg, terrain_height_sampler and terrain_height_sampler_check.
//
// The run starts with a directed set of writes and queries at the grid extremes,
// then steps through a list of grid sizes. For each size it writes both registers
// while the block is idle and sends a mix of random writes, queries inside the
// grid and queries past its edge. A query inside the grid is only sent once all
// four corners of its cell hold a written sample, since unwritten samples read
// back undefined; missing corners are written first, with random content.
module terrain_height_sampler_test;
  import ths_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int NUM_PHASES      = 9;
  localparam int DRAIN_TAIL      = 12;
  localparam int LONG_HOLD       = 500;  // result side holds off long enough to fill the pipe

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;   // x_pos [15:0], z_pos [31:16], sample [39:32]
  logic                 s_tuser   = 1'b0; // action [0]
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;          // height [15:0]
  logic                 m_tuser;          // out_of_range [0]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = 1'b0;
  logic [DIM_REG_W-1:0] cfg_data  = '0;

  int fail_count;
  int outstanding;
  int cycle_count   = 0;
  int burst_left    = 0;
  int hold_requests = 0;
  int cur_w         = 256;
  int cur_d         = 256;

  // One bit per store entry that has been written since reset.
  bit written_map [0:65535];

  always #4 clk = ~clk;

  terrain_height_sampler u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  terrain_height_sampler_check u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[terrain_height_sampler] ERROR");
      $finish;
    end
  end

  // Result side. It picks a readiness pattern for a random stretch of cycles, and on
  // request drops tready for a long stretch while the sender keeps offering beats.
  int ready_mode  = 0;
  int mode_left   = 0;
  int hold_left   = 0;
  int hold_served = 0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 128);
      end
      mode_left--;
      case (ready_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= ($urandom_range(0, 7) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Sends one beat. Beats come in bursts; between bursts tvalid often drops for a random gap.
  // Returns at the edge that accepted the beat, with tvalid still high.
  task automatic send_beat(input action_t act, input logic [POS_W-1:0] xp,
                           input logic [POS_W-1:0] zp, input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (act == ACT_WRITE) written_map[{zp[15:8], xp[15:8]}] = 1'b1;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {smp, zp, xp};
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  // Stops sending and waits until every expected result has arrived, then lets the
  // pipeline run empty so that trailing writes have landed too.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Writes both grid registers back to back; only called while the block is idle.
  task automatic write_dims(input logic [DIM_REG_W-1:0] w, input logic [DIM_REG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_GRID_DEPTH;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_d = d;
  endtask

  // Sample bytes lean toward the extremes so heights reach zero and full scale.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_query(input int col, input int row);
    int fx, fz;
    fx = $urandom_range(0, 255);
    fz = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: begin
        // Fractions summing to exactly one sit on the diagonal.
        if (fx == 0) fx = 1;
        fz = 256 - fx;
      end
      1: begin
        fx = 0;
        fz = 0;
      end
      2: begin
        fx = 255;
        fz = 255;
      end
      default: ;
    endcase
    send_beat(ACT_QUERY, {col[7:0], fx[7:0]}, {row[7:0], fz[7:0]}, pick_sample());
  endtask

  // Corners of a cell that are still unwritten get a sample first; now and then a
  // written corner is rewritten right before the query to catch stale reads.
  task automatic fill_corners(input int col, input int row);
    int c, r;
    for (int k = 0; k < 4; k++) begin
      c = col + (k & 1);
      r = row + (k >> 1);
      if (!written_map[{r[7:0], c[7:0]}] || $urandom_range(0, 15) == 0)
        send_beat(ACT_WRITE, {c[7:0], 8'($urandom_range(0, 255))},
                  {r[7:0], 8'($urandom_range(0, 255))}, pick_sample());
    end
  endtask

  task automatic random_item();
    int effw, effd, pick, col, row, hot_c, hot_r;
    effw = (cur_w > 256) ? 256 : cur_w;
    effd = (cur_d > 256) ? 256 : cur_d;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // Free write: half in the busy corner of the grid, half anywhere in the store.
      if ($urandom_range(0, 1) == 0)
        send_beat(ACT_WRITE, {4'h0, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))},
                  {4'h0, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))},
                  pick_sample());
      else
        send_beat(ACT_WRITE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  pick_sample());
    end else if (pick < 30 || effw < 2 || effd < 2) begin
      // Query past the grid edge: it returns height zero and the flag.
      if (effw < 2 || effd < 2) begin
        col = $urandom_range(0, 255);
        row = $urandom_range(0, 255);
      end else if ($urandom_range(0, 1) == 0) begin
        col = $urandom_range(effw - 1, 255);
        row = $urandom_range(0, 255);
      end else begin
        col = $urandom_range(0, 255);
        row = $urandom_range(effd - 1, 255);
      end
      send_query(col, row);
    end else begin
      hot_c = (effw - 2 < 15) ? effw - 2 : 15;
      hot_r = (effd - 2 < 15) ? effd - 2 : 15;
      case ($urandom_range(0, 9))
        0: begin
          col = effw - 2;
          row = $urandom_range(0, effd - 2);
        end
        1: begin
          col = $urandom_range(0, effw - 2);
          row = effd - 2;
        end
        2, 3: begin
          col = $urandom_range(0, effw - 2);
          row = $urandom_range(0, effd - 2);
        end
        default: begin
          col = $urandom_range(0, hot_c);
          row = $urandom_range(0, hot_r);
        end
      endcase
      fill_corners(col, row);
      send_query(col, row);
    end
  endtask

  // Directed opening at the reset grid of 256 by 256.
  task automatic directed_items();
    // Full-scale cell at the origin: both triangles give 255 in every corner.
    send_beat(ACT_WRITE, 16'h0000, 16'h0000, 8'd255);
    send_beat(ACT_WRITE, 16'h0100, 16'h0000, 8'd255);
    send_beat(ACT_WRITE, 16'h0000, 16'h0100, 8'd255);
    send_beat(ACT_WRITE, 16'h0100, 16'h0100, 8'd255);
    send_beat(ACT_QUERY, 16'h0000, 16'h0000, 8'h00);
    send_beat(ACT_QUERY, 16'h00FF, 16'h00FF, 8'hFF);
    // Fraction bits of a write position are dropped; this clears corner (0,0).
    send_beat(ACT_WRITE, 16'h00FF, 16'h00FF, 8'd0);
    send_beat(ACT_QUERY, 16'h0000, 16'h0000, 8'hAA);
    send_beat(ACT_QUERY, 16'h0001, 16'h0000, 8'h55);
    // Last full cell of the store, with uneven corners.
    send_beat(ACT_WRITE, 16'hFE00, 16'hFE00, 8'd0);
    send_beat(ACT_WRITE, 16'hFF00, 16'hFE00, 8'd255);
    send_beat(ACT_WRITE, 16'hFE00, 16'hFF00, 8'd128);
    send_beat(ACT_WRITE, 16'hFFFF, 16'hFFFF, 8'd7);
    send_beat(ACT_QUERY, 16'hFEFF, 16'hFE00, 8'h00);  // lower, one short of the diagonal
    send_beat(ACT_QUERY, 16'hFE80, 16'hFE80, 8'h00);  // diagonal tie goes upper
    send_beat(ACT_QUERY, 16'hFE01, 16'hFEFF, 8'h00);  // upper
    send_beat(ACT_QUERY, 16'hFEFF, 16'hFEFF, 8'h00);  // upper, next to the far corner
    // Queries whose far corner falls off the grid.
    send_beat(ACT_QUERY, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_beat(ACT_QUERY, 16'hFF00, 16'h0000, 8'h00);
    send_beat(ACT_QUERY, 16'h0000, 16'hFF00, 8'h00);
  endtask

  initial begin
    int w, d;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin w = 2;   d = 2;   end
        1: begin w = 511; d = 511; end
        2: begin w = 0;   d = 1;   end
        3: begin w = 17;  d = 5;   end
        4: begin w = 256; d = 2;   end
        5: begin w = 3;   d = 300; end
        6: begin
          w = $urandom_range(2, 40);
          d = $urandom_range(2, 40);
        end
        7: begin
          w = $urandom_range(0, 511);
          d = $urandom_range(0, 511);
        end
        default: begin w = 256; d = 256; end
      endcase
      write_dims(w[DIM_REG_W-1:0], d[DIM_REG_W-1:0]);
      // The long result-side hold-off starts while this phase is streaming.
      if (p == 1) hold_requests++;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_item();
        // One pause in mid-phase until every result is back.
        if (p == 3 && i == ITEMS_PER_PHASE / 2) wait_drained();
      end
      wait_drained();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("[terrain_height_sampler] OK");
    end else begin
      $display("[terrain_height_sampler] ERROR");
    end
    $finish;
  end

endmodule
